>>> rtl/htm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package htm_pkg;

  // Histogram geometry
  localparam int COUNT_BITS = 24;
  localparam int LEVEL_W    = 8;
  localparam int LOG_FRAC   = 24;
  localparam int LOG_W      = 5 + LOG_FRAC;
  localparam int S1_W       = COUNT_BITS + 8;
  localparam int S2_W       = COUNT_BITS + 16;
  localparam int S3_W       = COUNT_BITS + 24;
  localparam int SQ_W       = 2 * COUNT_BITS;
  localparam int ENT_W      = COUNT_BITS + LOG_W;

  // Arithmetic unit widths
  localparam int WIDE_W = 128;
  localparam int DIV_W  = 64;

  // Pixel queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  // Gray conversion weights (Q14)
  localparam int COEF_B  = 1868;
  localparam int COEF_G  = 9617;
  localparam int COEF_R  = 4899;
  localparam int GRAY_RND = 8192;

  // Stream payload widths
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 152;

  typedef enum logic {
    OP_MUL,
    OP_DIV
  } op_e;

  typedef struct packed {
    logic [LEVEL_W-1:0] gray;
    logic               last;
  } pix_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] n;
    logic [S1_W-1:0]       s1;
    logic [S2_W-1:0]       s2;
    logic [S3_W-1:0]       s3;
    logic [SQ_W-1:0]       sq;
    logic [ENT_W-1:0]      ent;
    logic [LOG_W-1:0]      lnn;
    logic                  sat;
  } sums_t;

  typedef struct packed {
    logic [23:0] mean_level;
    logic [23:0] first_moment;
    logic [29:0] variance;
    logic [30:0] third_moment;
    logic [16:0] uniformity;
    logic [19:0] entropy_bits;
    logic        status;
  } res_t;

endpackage
`default_nettype wire

>>> rtl/histogram_texture_moments.sv
// Pixels: one word per cycle into a 4-word queue while tready is high; each histogram update is
// a bin memory read, then a write, and the next pixel leaves the queue only after that write.
// Last pixel: sweep of 256 bins, with log2 by squaring for each nonzero bin, then log2
// of the count, then bit-serial multiply and divide before the result word appears on
// the master side.
// Reset: asynchronous active low; then a pass over all 256 bins clears the bin memory with tready low.
`timescale 1ns / 1ps
`default_nettype none
module histogram_texture_moments (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic         cfg_wdata_i,      // color_input
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [23:0]  s_axis_tdata,     // blue[7:0], green[15:8], red[23:16]
  input  wire logic         s_axis_tlast,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [151:0]      m_axis_tdata,     // mean_level[23:0], first_moment[47:24],
                                              // variance[77:48], third_moment[108:78],
                                              // uniformity[125:109], entropy_bits[145:126]
  output logic              m_axis_tuser      // status
);

  logic           q_full, q_empty, q_wr, q_rd, init_done;
  htm_pkg::pix_t  q_wdata, q_rdata;
  logic           sums_valid, sums_ready;
  htm_pkg::sums_t sums;
  htm_pkg::res_t  res;

  htm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .init_done_i (init_done),
    .q_full_i    (q_full),
    .q_wr_o      (q_wr),
    .q_wdata_o   (q_wdata)
  );

  htm_fifo u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_en_i (q_wr),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .rd_en_i (q_rd),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  htm_accum u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_rdata_i    (q_rdata),
    .q_rd_o       (q_rd),
    .init_done_o  (init_done),
    .sums_valid_o (sums_valid),
    .sums_o       (sums),
    .sums_ready_i (sums_ready)
  );

  htm_stats u_stats (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sums_valid_i (sums_valid),
    .sums_i       (sums),
    .sums_ready_o (sums_ready),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_o        (res)
  );

  // result word packing
  assign m_axis_tdata = {6'd0, res.entropy_bits, res.uniformity, res.third_moment,
                         res.variance, res.first_moment, res.mean_level};
  assign m_axis_tuser = res.status;

endmodule
`default_nettype wire

>>> rtl/htm_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module htm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

>>> rtl/htm_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module htm_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          wr_en_i,
  input  wire htm_pkg::pix_t wdata_i,
  output logic               full_o,
  input  wire logic          rd_en_i,
  output htm_pkg::pix_t      rdata_o,
  output logic               empty_o
);

  localparam int PW = htm_pkg::QPTR_W;

  htm_pkg::pix_t mem_q [htm_pkg::QDEPTH];
  logic [PW-1:0] wptr_q, rptr_q;
  logic [PW:0]   cnt_q;

  assign full_o  = (cnt_q == (PW+1)'(htm_pkg::QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr_en_i) wptr_q <= wptr_q + 1'b1;
      if (rd_en_i) rptr_q <= rptr_q + 1'b1;
      if (wr_en_i && !rd_en_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!wr_en_i && rd_en_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/htm_front.sv
`timescale 1ns / 1ps
`default_nettype none
module htm_front (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [23:0] in_data_i,
  input  wire logic        in_last_i,
  input  wire logic        init_done_i,
  input  wire logic        q_full_i,
  output logic             q_wr_o,
  output htm_pkg::pix_t    q_wdata_o
);

  logic        color_q;
  logic [21:0] wsum;
  logic [7:0]  gray;

  // mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q <= 1'b1;
    end else if (cfg_we_i) begin
      color_q <= cfg_wdata_i;
    end
  end

  // BGR to gray, Q14 weights with rounding, or the blue byte as is when color input is off
  always_comb begin
    wsum = 22'(in_data_i[7:0])   * 22'(htm_pkg::COEF_B)
         + 22'(in_data_i[15:8])  * 22'(htm_pkg::COEF_G)
         + 22'(in_data_i[23:16]) * 22'(htm_pkg::COEF_R)
         + 22'(htm_pkg::GRAY_RND);
    gray = color_q ? wsum[21:14] : in_data_i[7:0];
  end

  assign in_ready_o     = init_done_i && !q_full_i;
  assign q_wr_o         = in_valid_i && in_ready_o;
  assign q_wdata_o.gray = gray;
  assign q_wdata_o.last = in_last_i;

endmodule
`default_nettype wire

>>> rtl/htm_accum.sv
`timescale 1ns / 1ps
`default_nettype none
module htm_accum (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          q_empty_i,
  input  wire htm_pkg::pix_t q_rdata_i,
  output logic               q_rd_o,
  output logic               init_done_o,
  output logic               sums_valid_o,
  output htm_pkg::sums_t     sums_o,
  input  wire logic          sums_ready_i
);

  localparam int CB    = htm_pkg::COUNT_BITS;
  localparam int LW    = htm_pkg::LOG_W;
  localparam int EW    = htm_pkg::ENT_W;
  localparam int S1W   = htm_pkg::S1_W;
  localparam int S2W   = htm_pkg::S2_W;
  localparam int S3W   = htm_pkg::S3_W;
  localparam int SQW   = htm_pkg::SQ_W;
  localparam int FRAC  = htm_pkg::LOG_FRAC;

  localparam logic [3:0] A_CLR  = 4'd0;
  localparam logic [3:0] A_IDLE = 4'd1;
  localparam logic [3:0] A_INC  = 4'd2;
  localparam logic [3:0] A_SRD  = 4'd3;
  localparam logic [3:0] A_SDAT = 4'd4;
  localparam logic [3:0] A_SM1  = 4'd5;
  localparam logic [3:0] A_SM2  = 4'd6;
  localparam logic [3:0] A_SM3  = 4'd7;
  localparam logic [3:0] A_LOG  = 4'd8;
  localparam logic [3:0] A_LMUL = 4'd9;
  localparam logic [3:0] A_LACC = 4'd10;
  localparam logic [3:0] A_NEXT = 4'd11;
  localparam logic [3:0] A_HAND = 4'd12;

  logic [3:0]     state_q;
  logic [7:0]     idx_q, gray_q;
  logic           last_q, sat_q, lnn_mode_q;
  logic [CB-1:0]  total_q, c_q;
  logic [15:0]    i2_q;
  logic [23:0]    i3_q;
  logic [S1W-1:0] p1_q, s1_q;
  logic [S2W-1:0] p2_q, s2_q;
  logic [S3W-1:0] p3_q, s3_q;
  logic [SQW-1:0] psq_q, sq_q;
  logic [EW-1:0]  lp_q, ent_q;
  logic [31:0]    lm_q;
  logic [LW-1:0]  lr_q;
  logic [4:0]     lk_q;

  logic           ram_we;
  logic [7:0]     ram_waddr, ram_raddr;
  logic [CB-1:0]  ram_wdata, ram_rdata;
  logic [63:0]    lsq;
  logic [32:0]    lsh;

  htm_ram #(.WIDTH(CB), .DEPTH(256)) u_bins (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  function automatic logic [4:0] msb_pos(input logic [CB-1:0] v);
    logic [4:0] e;
    e = '0;
    for (int i = 0; i < CB; i++) begin
      if (v[i]) e = 5'(i);
    end
    return e;
  endfunction

  function automatic logic [31:0] log_norm(input logic [CB-1:0] v);
    logic [31:0] v32;
    v32 = 32'(v);
    return v32 << (5'd31 - msb_pos(v));
  endfunction

  // one squaring step of the log mantissa
  assign lsq = 64'(lm_q) * 64'(lm_q);
  assign lsh = lsq[63:31];

  assign q_rd_o       = (state_q == A_IDLE) && !q_empty_i;
  assign init_done_o  = (state_q != A_CLR);
  assign sums_valid_o = (state_q == A_HAND);

  assign sums_o.n   = total_q;
  assign sums_o.s1  = s1_q;
  assign sums_o.s2  = s2_q;
  assign sums_o.s3  = s3_q;
  assign sums_o.sq  = sq_q;
  assign sums_o.ent = ent_q;
  assign sums_o.lnn = lr_q;
  assign sums_o.sat = sat_q;

  // bin memory port control
  always_comb begin
    ram_raddr = (state_q == A_IDLE) ? q_rdata_i.gray : idx_q;
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = '0;
    case (state_q)
      A_CLR: begin
        ram_we = 1'b1;
      end
      A_INC: begin
        ram_we    = 1'b1;
        ram_waddr = gray_q;
        ram_wdata = ram_rdata + 1'b1;
      end
      A_SDAT: begin
        ram_we = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // histogram update and statistics sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= A_CLR;
      idx_q      <= '0;
      gray_q     <= '0;
      last_q     <= 1'b0;
      sat_q      <= 1'b0;
      lnn_mode_q <= 1'b0;
      total_q    <= '0;
      c_q        <= '0;
      i2_q       <= '0;
      i3_q       <= '0;
      p1_q       <= '0;
      p2_q       <= '0;
      p3_q       <= '0;
      psq_q      <= '0;
      lp_q       <= '0;
      s1_q       <= '0;
      s2_q       <= '0;
      s3_q       <= '0;
      sq_q       <= '0;
      ent_q      <= '0;
      lm_q       <= '0;
      lr_q       <= '0;
      lk_q       <= '0;
    end else begin
      case (state_q)
        A_CLR: begin
          idx_q <= idx_q + 1'b1;
          if (&idx_q) state_q <= A_IDLE;
        end
        A_IDLE: begin
          if (!q_empty_i) begin
            if (!(&total_q)) begin
              gray_q  <= q_rdata_i.gray;
              last_q  <= q_rdata_i.last;
              state_q <= A_INC;
            end else begin
              sat_q <= 1'b1;
              if (q_rdata_i.last) begin
                idx_q   <= '0;
                state_q <= A_SRD;
              end
            end
          end
        end
        A_INC: begin
          total_q <= total_q + 1'b1;
          if (last_q) begin
            idx_q   <= '0;
            state_q <= A_SRD;
          end else begin
            state_q <= A_IDLE;
          end
        end
        A_SRD: begin
          state_q <= A_SDAT;
        end
        A_SDAT: begin
          c_q     <= ram_rdata;
          i2_q    <= 16'(idx_q) * 16'(idx_q);
          state_q <= A_SM1;
        end
        A_SM1: begin
          p1_q    <= S1W'(c_q) * S1W'(idx_q);
          p2_q    <= S2W'(c_q) * S2W'(i2_q);
          psq_q   <= SQW'(c_q) * SQW'(c_q);
          i3_q    <= 24'(i2_q) * 24'(idx_q);
          state_q <= A_SM2;
        end
        A_SM2: begin
          s1_q    <= s1_q + p1_q;
          s2_q    <= s2_q + p2_q;
          sq_q    <= sq_q + psq_q;
          p3_q    <= S3W'(c_q) * S3W'(i3_q);
          lm_q    <= log_norm(c_q);
          lr_q    <= {msb_pos(c_q), {FRAC{1'b0}}};
          lk_q    <= 5'(FRAC - 1);
          state_q <= A_SM3;
        end
        A_SM3: begin
          s3_q    <= s3_q + p3_q;
          state_q <= (c_q != '0) ? A_LOG : A_NEXT;
        end
        A_LOG: begin
          if (lsh[32]) begin
            lm_q       <= lsh[32:1];
            lr_q[lk_q] <= 1'b1;
          end else begin
            lm_q <= lsh[31:0];
          end
          lk_q <= lk_q - 1'b1;
          if (lk_q == '0) begin
            state_q <= lnn_mode_q ? A_HAND : A_LMUL;
          end
        end
        A_LMUL: begin
          lp_q    <= EW'(c_q) * EW'(lr_q);
          state_q <= A_LACC;
        end
        A_LACC: begin
          ent_q   <= ent_q + lp_q;
          state_q <= A_NEXT;
        end
        A_NEXT: begin
          if (&idx_q) begin
            // log2 of the pixel count
            if (total_q != '0) begin
              c_q        <= total_q;
              lm_q       <= log_norm(total_q);
              lr_q       <= {msb_pos(total_q), {FRAC{1'b0}}};
              lk_q       <= 5'(FRAC - 1);
              lnn_mode_q <= 1'b1;
              state_q    <= A_LOG;
            end else begin
              lr_q    <= '0;
              state_q <= A_HAND;
            end
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= A_SRD;
          end
        end
        A_HAND: begin
          if (sums_ready_i) begin
            s1_q       <= '0;
            s2_q       <= '0;
            s3_q       <= '0;
            sq_q       <= '0;
            ent_q      <= '0;
            total_q    <= '0;
            sat_q      <= 1'b0;
            lnn_mode_q <= 1'b0;
            state_q    <= A_IDLE;
          end
        end
        default: begin
          state_q <= A_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/htm_muldiv.sv
`timescale 1ns / 1ps
`default_nettype none
module htm_muldiv (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire htm_pkg::op_e op_i,
  input  wire logic [127:0] a_i,
  input  wire logic [63:0]  b_i,
  output logic              done_o,
  output logic [127:0]      res_o
);

  logic         busy_q, done_q;
  htm_pkg::op_e op_q;
  logic [6:0]   cnt_q;
  logic [127:0] acc_q, x_q;
  logic [63:0]  y_q, rem_q;
  logic [64:0]  rtry;
  logic         qbit;

  // restoring division trial
  always_comb begin
    rtry = {rem_q, x_q[127]};
    qbit = (rtry >= {1'b0, y_q});
  end

  assign done_o = done_q;
  assign res_o  = acc_q;

  // shift-add multiply, one multiplier bit per cycle; divide, one quotient bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= htm_pkg::OP_MUL;
      cnt_q  <= '0;
      acc_q  <= '0;
      x_q    <= '0;
      y_q    <= '0;
      rem_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        op_q   <= op_i;
        cnt_q  <= (op_i == htm_pkg::OP_MUL) ? 7'd63 : 7'd127;
        acc_q  <= '0;
        x_q    <= a_i;
        y_q    <= b_i;
        rem_q  <= '0;
      end else if (busy_q) begin
        if (op_q == htm_pkg::OP_MUL) begin
          if (y_q[0]) acc_q <= acc_q + x_q;
          x_q <= x_q << 1;
          y_q <= y_q >> 1;
        end else begin
          rem_q <= qbit ? 64'(rtry - {1'b0, y_q}) : rtry[63:0];
          acc_q <= {acc_q[126:0], qbit};
          x_q   <= x_q << 1;
        end
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/htm_stats.sv
`timescale 1ns / 1ps
`default_nettype none
module htm_stats (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           sums_valid_i,
  input  wire htm_pkg::sums_t sums_i,
  output logic                sums_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output htm_pkg::res_t       out_o
);

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_N2   = 5'd1;
  localparam logic [4:0] ST_MEAN = 5'd2;
  localparam logic [4:0] ST_NS2  = 5'd3;
  localparam logic [4:0] ST_S11  = 5'd4;
  localparam logic [4:0] ST_VAR  = 5'd5;
  localparam logic [4:0] ST_N2S3 = 5'd6;
  localparam logic [4:0] ST_S111 = 5'd7;
  localparam logic [4:0] ST_Q    = 5'd8;
  localparam logic [4:0] ST_N3   = 5'd9;
  localparam logic [4:0] ST_D1   = 5'd10;
  localparam logic [4:0] ST_D2   = 5'd11;
  localparam logic [4:0] ST_D3   = 5'd12;
  localparam logic [4:0] ST_UNI  = 5'd13;
  localparam logic [4:0] ST_LNN  = 5'd14;
  localparam logic [4:0] ST_ENT  = 5'd15;
  localparam logic [4:0] ST_DONE = 5'd16;

  logic [4:0]     step_q;
  logic           run_q, out_valid_q, neg_q;
  htm_pkg::sums_t sums_q;
  htm_pkg::res_t  res_q;
  logic [63:0]    n2_q, a_q;
  logic [127:0]   ns2_q, s11_q, p_q, q_q, mag_q;

  logic           md_start, md_done;
  htm_pkg::op_e   md_op;
  logic [127:0]   md_a, md_res;
  logic [63:0]    md_b;
  logic [127:0]   n_w;
  logic           neg;
  logic [127:0]   mag_base;
  logic [29:0]    v30;
  logic           ent_pos;

  htm_muldiv u_md (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (md_start),
    .op_i    (md_op),
    .a_i     (md_a),
    .b_i     (md_b),
    .done_o  (md_done),
    .res_o   (md_res)
  );

  assign n_w          = 128'(sums_q.n);
  assign neg          = (p_q < q_q);
  assign mag_base     = neg ? (q_q - p_q) : (p_q - q_q);
  assign v30          = (|md_res[127:30]) ? 30'h3FFFFFFF : md_res[29:0];
  assign ent_pos      = (a_q > 64'(sums_q.ent));
  assign sums_ready_o = (step_q == ST_IDLE) && !out_valid_q;
  assign out_valid_o  = out_valid_q;
  assign out_o        = res_q;

  // operands of the current step
  always_comb begin
    md_op = htm_pkg::OP_MUL;
    md_a  = '0;
    md_b  = '0;
    case (step_q)
      ST_N2: begin
        md_a = n_w;
        md_b = n_w[63:0];
      end
      ST_MEAN: begin
        md_op = htm_pkg::OP_DIV;
        md_a  = (128'(sums_q.s1) << 16) + (n_w >> 1);
        md_b  = n_w[63:0];
      end
      ST_NS2: begin
        md_a = 128'(sums_q.s2);
        md_b = n_w[63:0];
      end
      ST_S11: begin
        md_a = 128'(sums_q.s1);
        md_b = 64'(sums_q.s1);
      end
      ST_VAR: begin
        md_op = htm_pkg::OP_DIV;
        md_a  = ((ns2_q - s11_q) << 16) + 128'(n2_q >> 1);
        md_b  = n2_q;
      end
      ST_N2S3: begin
        md_a = 128'(sums_q.s3);
        md_b = n2_q;
      end
      ST_S111: begin
        md_a = s11_q;
        md_b = 64'(sums_q.s1);
      end
      ST_Q: begin
        md_a = ns2_q;
        md_b = 64'(sums_q.s1);
      end
      ST_N3: begin
        md_a = 128'(n2_q);
        md_b = n_w[63:0];
      end
      ST_D1, ST_D2, ST_D3: begin
        md_op = htm_pkg::OP_DIV;
        md_a  = mag_q;
        md_b  = n_w[63:0];
      end
      ST_UNI: begin
        md_op = htm_pkg::OP_DIV;
        md_a  = (128'(sums_q.sq) << 16) + 128'(n2_q >> 1);
        md_b  = n2_q;
      end
      ST_LNN: begin
        md_a = 128'(sums_q.lnn);
        md_b = n_w[63:0];
      end
      ST_ENT: begin
        md_op = htm_pkg::OP_DIV;
        md_a  = 128'((a_q - 64'(sums_q.ent)) + (n_w[63:0] << 7));
        md_b  = n_w[63:0] << 8;
      end
      default: begin
        md_op = htm_pkg::OP_MUL;
      end
    endcase
  end

  assign md_start = !run_q && (step_q != ST_IDLE) && (step_q != ST_DONE)
                    && !((step_q == ST_ENT) && !ent_pos);

  // statistics sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= ST_IDLE;
      run_q       <= 1'b0;
      out_valid_q <= 1'b0;
      neg_q       <= 1'b0;
      sums_q      <= '0;
      res_q       <= '0;
      n2_q        <= '0;
      a_q         <= '0;
      ns2_q       <= '0;
      s11_q       <= '0;
      p_q         <= '0;
      q_q         <= '0;
      mag_q       <= '0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (md_start) run_q <= 1'b1;

      case (step_q)
        ST_IDLE: begin
          if (sums_valid_i && !out_valid_q) begin
            sums_q <= sums_i;
            // status sits in the lowest bit, all statistics start at zero
            res_q  <= {{($bits(htm_pkg::res_t)-1){1'b0}}, sums_i.sat};
            step_q <= (sums_i.n != '0) ? ST_N2 : ST_DONE;
          end
        end
        ST_ENT: begin
          if (!run_q && !ent_pos) begin
            step_q <= ST_DONE;
          end else if (md_done) begin
            res_q.entropy_bits <= (md_res > 128'd524288) ? 20'd524288 : md_res[19:0];
            run_q  <= 1'b0;
            step_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          out_valid_q <= 1'b1;
          step_q      <= ST_IDLE;
        end
        default: begin
          if (md_done) begin
            run_q  <= 1'b0;
            step_q <= step_q + 1'b1;
            case (step_q)
              ST_N2:   n2_q <= md_res[63:0];
              ST_MEAN: res_q.mean_level <= md_res[23:0];
              ST_NS2:  ns2_q <= md_res;
              ST_S11:  s11_q <= md_res;
              ST_VAR:  res_q.variance <= md_res[29:0];
              ST_N2S3: p_q <= md_res;
              ST_S111: p_q <= p_q + (md_res << 1);
              ST_Q:    q_q <= md_res + (md_res << 1);
              ST_N3: begin
                neg_q <= neg;
                mag_q <= (mag_base << 8) + (md_res >> 1);
              end
              ST_D1, ST_D2: mag_q <= md_res;
              ST_D3: begin
                res_q.third_moment <= neg_q ? (31'd0 - {1'b0, v30}) : {1'b0, v30};
              end
              ST_UNI:  res_q.uniformity <= md_res[16:0];
              ST_LNN:  a_q <= md_res[63:0];
              default: a_q <= a_q;
            endcase
          end
        end
      endcase
    end
  end

endmodule
`default_nettype wire
